// ----- sv/rth_pkg.sv -----
`default_nettype none
package rth_pkg;

  // earth model and fixed-point constants
  localparam int unsigned EARTH_RADIUS_M = 6371000;
  localparam logic [63:0] PI_Q60         = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_Q45         = PI_Q60 >> 15;
  localparam logic [29:0] GAIN_INV_Q30   = 30'd652032874;

  // datapath widths
  localparam int unsigned XW  = 34;  // rotation x/y, Q30
  localparam int unsigned ZW  = 64;  // rotation angle, Q60
  localparam int unsigned PW  = 57;  // range times sine/cosine
  localparam int unsigned SW  = 58;  // r1 sum
  localparam int unsigned VW  = 54;  // vectoring x/y, Q24
  localparam int unsigned CIW = 3;   // config index width
  localparam int unsigned CDW = 22;  // config data width

  // config register indexes
  typedef enum logic [CIW-1:0] {
    REG_RANGE_MIN  = 3'd0,
    REG_RANGE_MAX  = 3'd1,
    REG_ELEV_MIN   = 3'd2,
    REG_ELEV_MAX   = 3'd3,
    REG_AZIM_MIN   = 3'd4,
    REG_AZIM_MAX   = 3'd5,
    REG_SITE_H_MIN = 3'd6,
    REG_SITE_H_MAX = 3'd7
  } cfg_reg_t;

  // rotation pipeline payload
  typedef struct packed {
    logic                 valid;
    logic                 inv;
    logic                 negcos;
    logic [21:0]          rng;
    logic signed [17:0]   hgt;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_t;

  // vectoring pipeline payload
  typedef struct packed {
    logic                 valid;
    logic                 inv;
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
  } vec_t;

  // arctan(2^-i) in Q60 from the truncated series
  function automatic logic [63:0] atan_q60(input int unsigned i);
    logic [63:0] acc;
    logic [63:0] term;
    int unsigned ex;
    acc = 64'd0;
    if (i == 0) begin
      return PI_Q60 >> 2;
    end
    for (int unsigned k = 0; k < 32; k++) begin
      ex = i * (2 * k + 1);
      if (ex <= 60) begin
        term = (64'd1 << (60 - ex)) / 64'(2 * k + 1);
        if (k[0]) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

// ----- sv/rth_front.sv -----
`default_nettype none
module rth_front
  import rth_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               cfg_we,
  input  wire logic [CIW-1:0]     cfg_idx,
  input  wire logic [CDW-1:0]     cfg_wdata,
  input  wire logic               in_valid,
  input  wire logic [21:0]        in_slant_range,
  input  wire logic signed [15:0] in_elevation,
  input  wire logic [15:0]        in_azimuth,
  input  wire logic signed [17:0] in_site_height,
  output rot_t                    rot_o
);

  logic [21:0]        range_min_r, range_max_r;
  logic signed [15:0] elev_min_r, elev_max_r;
  logic [15:0]        azim_min_r, azim_max_r;
  logic signed [17:0] sh_min_r, sh_max_r;
  rot_t               rot_r, rot_nxt;
  logic               oob;
  logic signed [16:0] e_f;
  logic               negcos;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r <= 22'd0;
      range_max_r <= 22'h3FFFFF;
      elev_min_r  <= -16'sd32768;
      elev_max_r  <= 16'sd32767;
      azim_min_r  <= 16'd0;
      azim_max_r  <= 16'hFFFF;
      sh_min_r    <= -18'sd2048;
      sh_max_r    <= 18'sd131071;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_RANGE_MIN:  range_min_r <= cfg_wdata;
        REG_RANGE_MAX:  range_max_r <= cfg_wdata;
        REG_ELEV_MIN:   elev_min_r  <= $signed(cfg_wdata[15:0]);
        REG_ELEV_MAX:   elev_max_r  <= $signed(cfg_wdata[15:0]);
        REG_AZIM_MIN:   azim_min_r  <= cfg_wdata[15:0];
        REG_AZIM_MAX:   azim_max_r  <= cfg_wdata[15:0];
        REG_SITE_H_MIN: sh_min_r    <= $signed(cfg_wdata[17:0]);
        REG_SITE_H_MAX: sh_max_r    <= $signed(cfg_wdata[17:0]);
        default: ;
      endcase
    end
  end

  // bound checks
  assign oob = (in_slant_range < range_min_r) || (in_slant_range > range_max_r) ||
               (in_elevation < elev_min_r) || (in_elevation > elev_max_r) ||
               (in_azimuth < azim_min_r) || (in_azimuth > azim_max_r) ||
               (in_site_height < sh_min_r) || (in_site_height > sh_max_r);

  // fold elevation into [-pi/2, pi/2]
  always_comb begin
    negcos = 1'b0;
    e_f    = 17'(in_elevation);
    if (in_elevation > 16'sd16384) begin
      e_f    = 17'sd32768 - 17'(in_elevation);
      negcos = 1'b1;
    end else if (in_elevation < -16'sd16384) begin
      e_f    = -17'sd32768 - 17'(in_elevation);
      negcos = 1'b1;
    end
  end

  // initial rotation vector and angle
  always_comb begin
    rot_nxt.valid  = in_valid;
    rot_nxt.inv    = oob;
    rot_nxt.negcos = negcos;
    rot_nxt.rng    = in_slant_range;
    rot_nxt.hgt    = in_site_height;
    rot_nxt.x      = XW'({1'b0, GAIN_INV_Q30});
    rot_nxt.y      = '0;
    rot_nxt.z      = ZW'(64'(e_f) * $signed({1'b0, PI_Q45[62:0]}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r.valid <= 1'b0;
    end else if (en) begin
      rot_r.valid <= rot_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r.inv    <= rot_nxt.inv;
      rot_r.negcos <= rot_nxt.negcos;
      rot_r.rng    <= rot_nxt.rng;
      rot_r.hgt    <= rot_nxt.hgt;
      rot_r.x      <= rot_nxt.x;
      rot_r.y      <= rot_nxt.y;
      rot_r.z      <= rot_nxt.z;
    end
  end

  assign rot_o = rot_r;

endmodule
`default_nettype wire

// ----- sv/rth_rot_stage.sv -----
`default_nettype none
module rth_rot_stage
  import rth_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  rot_t      rot_i,
  output rot_t      rot_o
);

  localparam logic signed [ZW-1:0] ATAN = $signed(atan_q60(IDX));

  rot_t                 rot_r, rot_nxt;
  logic signed [XW-1:0] dx, dy;

  assign dx = rot_i.y >>> IDX;
  assign dy = rot_i.x >>> IDX;

  // one micro-rotation toward zero residual angle
  always_comb begin
    rot_nxt = rot_i;
    if (rot_i.z >= 0) begin
      rot_nxt.x = rot_i.x - dx;
      rot_nxt.y = rot_i.y + dy;
      rot_nxt.z = rot_i.z - ATAN;
    end else begin
      rot_nxt.x = rot_i.x + dx;
      rot_nxt.y = rot_i.y - dy;
      rot_nxt.z = rot_i.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r.valid <= 1'b0;
    end else if (en) begin
      rot_r.valid <= rot_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r.inv    <= rot_nxt.inv;
      rot_r.negcos <= rot_nxt.negcos;
      rot_r.rng    <= rot_nxt.rng;
      rot_r.hgt    <= rot_nxt.hgt;
      rot_r.x      <= rot_nxt.x;
      rot_r.y      <= rot_nxt.y;
      rot_r.z      <= rot_nxt.z;
    end
  end

  assign rot_o = rot_r;

endmodule
`default_nettype wire

// ----- sv/rth_vec_stage.sv -----
`default_nettype none
module rth_vec_stage
  import rth_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  vec_t      vec_i,
  output vec_t      vec_o
);

  vec_t                 vec_r, vec_nxt;
  logic signed [VW-1:0] dx, dy;

  assign dx = vec_i.y >>> IDX;
  assign dy = vec_i.x >>> IDX;

  // one micro-rotation driving y to zero
  always_comb begin
    vec_nxt = vec_i;
    if (vec_i.y >= 0) begin
      vec_nxt.x = vec_i.x + dx;
      vec_nxt.y = vec_i.y - dy;
    end else begin
      vec_nxt.x = vec_i.x - dx;
      vec_nxt.y = vec_i.y + dy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_r.valid <= 1'b0;
    end else if (en) begin
      vec_r.valid <= vec_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r.inv <= vec_nxt.inv;
      vec_r.x   <= vec_nxt.x;
      vec_r.y   <= vec_nxt.y;
    end
  end

  assign vec_o = vec_r;

endmodule
`default_nettype wire

// ----- sv/radar_target_height.sv -----
// radar target height over a spherical earth
//
// input channel: in_valid/in_ready with slant range, elevation, azimuth and
// site height; one request may be accepted every clock cycle while in_ready is high.
// result channel: out_valid/out_ready with target height (meters, signed)
// and an invalid flag; an out of bounds request returns -1 with invalid set.
// configuration: cfg_we writes cfg_wdata to the bound register cfg_idx; the user
// must write only while the pipeline is empty, which the block itself does not enforce.
// pipeline registers, in order: one for the bound check and angle scaling,
// one per sine/cosine rotation stage, two for the range products and
// rounding, one per magnitude stage, one for the gain multiply and one
// for the output register.
// throughput is one request per cycle while not stalled; every stage is a register stage.
// the whole pipeline advances together: when the output holds a result
// and out_ready is low, every stage and in_ready hold until it is taken.
// reset clears all valid bits and loads the default bounds.
`default_nettype none
module radar_target_height
  import rth_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CIW-1:0]     cfg_idx,
  input  wire logic [CDW-1:0]     cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [21:0]        in_slant_range,
  input  wire logic signed [15:0] in_elevation,
  input  wire logic [15:0]        in_azimuth,
  input  wire logic signed [17:0] in_site_height,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [23:0]      out_target_height,
  output logic                    out_invalid
);

  logic en;
  rot_t rot_s [0:CORDIC_STAGES];
  vec_t vec_s [0:CORDIC_STAGES];

  // whole pipeline advances when the output slot frees up
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  rth_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_slant_range (in_slant_range),
    .in_elevation   (in_elevation),
    .in_azimuth     (in_azimuth),
    .in_site_height (in_site_height),
    .rot_o          (rot_s[0])
  );

  // sine/cosine rotation stages
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    rth_rot_stage #(.IDX(i)) u_rot (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .rot_i (rot_s[i]),
      .rot_o (rot_s[i+1])
    );
  end

  // range times sine and cosine
  logic                 a_valid_r;
  logic                 a_inv_r;
  logic signed [PW-1:0] a_py_r, a_px_r;
  logic signed [24:0]   a_base_r;
  logic signed [XW-1:0] cos_v;

  assign cos_v = rot_s[CORDIC_STAGES].negcos ? -rot_s[CORDIC_STAGES].x
                                              : rot_s[CORDIC_STAGES].x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= rot_s[CORDIC_STAGES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_inv_r  <= rot_s[CORDIC_STAGES].inv;
      a_py_r   <= PW'($signed({1'b0, rot_s[CORDIC_STAGES].rng}) * rot_s[CORDIC_STAGES].y);
      a_px_r   <= PW'($signed({1'b0, rot_s[CORDIC_STAGES].rng}) * cos_v);
      a_base_r <= 25'($signed({1'b0, 24'(EARTH_RADIUS_M)})) +
                  25'(rot_s[CORDIC_STAGES].hgt);
    end
  end

  // r1, absolute values and rounding to Q24
  logic signed [SW-1:0] r1, p1;
  logic [SW-1:0]        ar_full, ap_full;
  vec_t                 vec0_r;

  always_comb begin
    r1      = (SW'(a_base_r) <<< 30) + SW'(a_py_r);
    p1      = SW'(a_px_r);
    ar_full = (r1 < 0) ? SW'(-r1) : SW'(r1);
    ap_full = (p1 < 0) ? SW'(-p1) : SW'(p1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec0_r.valid <= 1'b0;
    end else if (en) begin
      vec0_r.valid <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec0_r.inv <= a_inv_r;
      vec0_r.x   <= $signed(VW'((ar_full + SW'(32)) >> 6));
      vec0_r.y   <= $signed(VW'((ap_full + SW'(32)) >> 6));
    end
  end

  assign vec_s[0] = vec0_r;

  // magnitude stages
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    rth_vec_stage #(.IDX(i)) u_vec (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vec_i (vec_s[i]),
      .vec_o (vec_s[i+1])
    );
  end

  // gain correction, split into high and low partial products
  logic        c_valid_r;
  logic        c_inv_r;
  logic [59:0] c_hi_r;
  logic [53:0] c_lo_r;
  logic [VW-1:0] mag;

  assign mag = vec_s[CORDIC_STAGES].x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= vec_s[CORDIC_STAGES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_inv_r <= vec_s[CORDIC_STAGES].inv;
      c_hi_r  <= 60'(mag[VW-1:24]) * 60'(GAIN_INV_Q30);
      c_lo_r  <= 54'(mag[23:0]) * 54'(GAIN_INV_Q30);
    end
  end

  // round to meters and subtract the earth radius
  logic [59:0] t_sum;
  logic [31:0] hgt_full;
  logic        out_valid_r;
  logic signed [23:0] out_hgt_r;
  logic        out_inv_r;

  always_comb begin
    t_sum    = c_hi_r + 60'(c_lo_r >> 24) + (60'd1 << 29);
    hgt_full = 32'(t_sum >> 30) - 32'(EARTH_RADIUS_M);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_inv_r <= c_inv_r;
      out_hgt_r <= c_inv_r ? -24'sd1 : $signed(hgt_full[23:0]);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_target_height = out_hgt_r;
  assign out_invalid       = out_inv_r;

endmodule
`default_nettype wire

// ----- sv/rth_checker.sv -----
`default_nettype none
module rth_checker
  import rth_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [23:0] out_target_height,
  input wire logic               out_invalid
);

  // an out of bounds request always reports -1
  a_inv_height: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_target_height == -24'sd1)
    else $error("invalid result without -1 height");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

  // an empty output slot never blocks requests
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request blocked with empty output");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_target_height) &&
                                $stable(out_invalid))
    else $error("stalled result changed");

endmodule

bind radar_target_height rth_checker u_rth_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_target_height (out_target_height),
  .out_invalid       (out_invalid)
);
`default_nettype wire

// ----- tb/radar_target_height_tb.sv -----
`timescale 1ns / 1ps
module radar_target_height_tb;
  import rth_pkg::*;

  localparam longint EARTH_M   = 6371000;
  localparam longint GAIN_Q30  = 652032874;
  localparam int     STAGES    = 24;
  localparam int     LATENCY   = 2 * STAGES + 5;
  localparam int     MAX_CYCLES = 400000;

  typedef struct {
    logic signed [23:0] height;
    logic               bad;
  } height_result_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  cfg_reg_t           cfg_idx;
  logic [21:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [21:0]        in_slant_range;
  logic signed [15:0] in_elevation;
  logic [15:0]        in_azimuth;
  logic signed [17:0] in_site_height;
  logic               out_valid;
  logic               out_ready;
  logic signed [23:0] out_target_height;
  logic               out_invalid;

  // bound registers as the block should hold them
  logic [21:0] range_lo, range_hi;
  logic [15:0] elev_lo, elev_hi, azim_lo, azim_hi;
  logic [17:0] site_lo, site_hi;

  height_result_t pending_heights[$];
  longint         arctan_q60[STAGES];
  int             fail_count;
  int             result_count;
  int             invalid_count;
  int             cycle_count;
  bit             steady;

  radar_target_height DUT (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_wdata,
    .in_valid, .in_ready, .in_slant_range, .in_elevation, .in_azimuth,
    .in_site_height, .out_valid, .out_ready, .out_target_height, .out_invalid
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // arctan(2^-i) in Q60 by the alternating series
  function automatic longint arctan_step(int i);
    longint unsigned sum;
    int k;
    sum = 0;
    if (i == 0) begin
      return longint'(64'h3243F6A8885A308D >> 2);
    end
    k = 0;
    while (i * (2 * k + 1) <= 60) begin
      if (k % 2 == 1) begin
        sum -= (64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1);
      end else begin
        sum += (64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1);
      end
      k++;
    end
    return longint'(sum);
  endfunction

  // spherical earth height for one measurement
  function automatic height_result_t predict_height(logic [21:0] rng,
      logic signed [15:0] elev, logic [15:0] azim, logic signed [17:0] site);
    height_result_t res;
    longint e, x, y, z, dx, dy, r1, p1;
    longint unsigned ar, ap, mag, t;
    bit flip;
    flip = 0;
    if (rng < range_lo || rng > range_hi ||
        elev < $signed(elev_lo) || elev > $signed(elev_hi) ||
        azim < azim_lo || azim > azim_hi ||
        site < $signed(site_lo) || site > $signed(site_hi)) begin
      res.height = -24'sd1;
      res.bad = 1'b1;
      return res;
    end
    e = elev;
    // fold beyond +-pi/2
    if (e > 16384) begin
      e = 32768 - e;
      flip = 1;
    end else if (e < -16384) begin
      e = -32768 - e;
      flip = 1;
    end
    // rotation for sine and cosine
    x = GAIN_Q30;
    y = 0;
    z = e * longint'(64'h3243F6A8885A308D >> 15);
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q60[i];
      end else begin
        x += dx; y -= dy; z += arctan_q60[i];
      end
    end
    if (flip) x = -x;
    r1 = (EARTH_M + longint'(site)) * (longint'(1) << 30) + longint'(rng) * y;
    p1 = longint'(rng) * x;
    ar = (r1 < 0) ? -r1 : r1;
    ap = (p1 < 0) ? -p1 : p1;
    ar = (ar + 32) >> 6;
    ap = (ap + 32) >> 6;
    // vectoring for the magnitude
    x = ar;
    y = ap;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy;
      end else begin
        x -= dx; y += dy;
      end
    end
    mag = x;
    t = (mag >> 24) * GAIN_Q30 + (((mag & 64'hFFFFFF) * GAIN_Q30) >> 24);
    t = (t + (64'd1 << 29)) >> 30;
    res.height = 24'(longint'(t) - EARTH_M);
    res.bad = 1'b0;
    return res;
  endfunction

  // send one request, with random idle cycles first unless steady is set
  task automatic send_measurement(logic [21:0] rng, logic signed [15:0] elev,
      logic [15:0] azim, logic signed [17:0] site);
    while (!steady && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_slant_range <= rng;
    in_elevation   <= elev;
    in_azimuth     <= azim;
    in_site_height <= site;
    do @(posedge clk); while (!in_ready);
    pending_heights.push_back(predict_height(rng, elev, azim, site));
  endtask

  // wait until the pipeline is empty
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_bound(cfg_reg_t idx, logic [21:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RANGE_MIN:  range_lo = val;
      REG_RANGE_MAX:  range_hi = val;
      REG_ELEV_MIN:   elev_lo  = val[15:0];
      REG_ELEV_MAX:   elev_hi  = val[15:0];
      REG_AZIM_MIN:   azim_lo  = val[15:0];
      REG_AZIM_MAX:   azim_hi  = val[15:0];
      REG_SITE_H_MIN: site_lo  = val[17:0];
      REG_SITE_H_MAX: site_hi  = val[17:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic open_all_bounds();
    write_bound(REG_RANGE_MIN, 22'd0);
    write_bound(REG_RANGE_MAX, 22'h3FFFFF);
    write_bound(REG_ELEV_MIN, 22'(16'h8000));
    write_bound(REG_ELEV_MAX, 22'(16'h7FFF));
    write_bound(REG_AZIM_MIN, 22'd0);
    write_bound(REG_AZIM_MAX, 22'(16'hFFFF));
    write_bound(REG_SITE_H_MIN, 22'(18'h3F800));
    write_bound(REG_SITE_H_MAX, 22'(18'h1FFFF));
  endtask

  // field extremes, angle folding, below-earth targets
  task automatic test_extremes();
    logic signed [15:0] angles[9] = '{0, 16384, -16384, 16385, -16385,
                                      32767, -32768, 1, -1};
    foreach (angles[i]) send_measurement(22'd100000, angles[i], 16'd0, 18'sd0);
    send_measurement(22'd0, 16'sd0, 16'hFFFF, -18'sd2048);
    send_measurement(22'h3FFFFF, 16'sd8192, 16'h8000, 18'sd131071);
    send_measurement(22'h3FFFFF, -16'sd16384, 16'h7FFF, 18'sd0);
    send_measurement(22'h3FFFFF, -16'sd4000, 16'h1234, -18'sd2048);
    send_measurement(22'h2AAAAA, 16'sd32767, 16'h5555, 18'sd65535);
    send_measurement(22'h155555, -16'sd32768, 16'hAAAA, 18'sd1000);
    // site height under the accepted floor
    send_measurement(22'd5000, 16'sd100, 16'd10, -18'sd2049);
    send_measurement(22'd5000, 16'sd100, 16'd10, -18'sd131072);
  endtask

  // narrow bounds: edges on both sides, then minimum above maximum
  task automatic test_bounds();
    drain_pipeline();
    write_bound(REG_RANGE_MIN, 22'd1000);
    write_bound(REG_RANGE_MAX, 22'd200000);
    write_bound(REG_ELEV_MIN, 22'(-16'sd500));
    write_bound(REG_ELEV_MAX, 22'(16'sd9000));
    write_bound(REG_AZIM_MIN, 22'd100);
    write_bound(REG_AZIM_MAX, 22'd60000);
    write_bound(REG_SITE_H_MIN, 22'(-18'sd100));
    write_bound(REG_SITE_H_MAX, 22'(18'sd5000));
    send_measurement(22'd1000, -16'sd500, 16'd100, -18'sd100);
    send_measurement(22'd200000, 16'sd9000, 16'd60000, 18'sd5000);
    send_measurement(22'd999, 16'sd0, 16'd200, 18'sd0);
    send_measurement(22'd200001, 16'sd0, 16'd200, 18'sd0);
    send_measurement(22'd5000, -16'sd501, 16'd200, 18'sd0);
    send_measurement(22'd5000, 16'sd9001, 16'd200, 18'sd0);
    send_measurement(22'd5000, 16'sd0, 16'd99, 18'sd0);
    send_measurement(22'd5000, 16'sd0, 16'd60001, 18'sd0);
    send_measurement(22'd5000, 16'sd0, 16'd200, -18'sd101);
    send_measurement(22'd5000, 16'sd0, 16'd200, 18'sd5001);
    drain_pipeline();
    write_bound(REG_AZIM_MIN, 22'd50000);
    write_bound(REG_AZIM_MAX, 22'd40000);
    send_measurement(22'd5000, 16'sd0, 16'd45000, 18'sd0);
    drain_pipeline();
    open_all_bounds();
  endtask

  task automatic random_measurement();
    logic [21:0] rng;
    logic signed [17:0] site;
    rng = ($urandom_range(3) == 0) ? 22'($urandom) : 22'($urandom_range(200000));
    site = ($urandom_range(19) == 0) ? 18'($urandom) :
           18'($urandom_range(133119) - 2048);
    send_measurement(rng, 16'($urandom), 16'($urandom), site);
  endtask

  // random traffic under open bounds, then under tightened bounds
  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      steady = (i >= 300 && i < 600);
      if (i == count / 2) begin
        // hold off until the pipeline empties, then tighten bounds
        drain_pipeline();
        write_bound(REG_RANGE_MIN, 22'($urandom_range(20000)));
        write_bound(REG_RANGE_MAX, 22'($urandom_range(100000, 4194303)));
        write_bound(REG_ELEV_MIN, 22'(16'($urandom_range(20000)) - 16'd25000));
        write_bound(REG_ELEV_MAX, 22'($urandom_range(30000)));
        write_bound(REG_AZIM_MIN, 22'($urandom_range(5000)));
        write_bound(REG_AZIM_MAX, 22'($urandom_range(60000, 65535)));
        write_bound(REG_SITE_H_MIN, 22'(18'($urandom_range(3000)) - 18'd2048));
        write_bound(REG_SITE_H_MAX, 22'($urandom_range(90000, 131071)));
      end
      random_measurement();
    end
    steady = 0;
  endtask

  // result ready with random stalls outside the steady phase
  always @(posedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 24);
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    height_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_heights.size() == 0) begin
        $display("%0t: unexpected result height=%0d invalid=%0b",
                 $time, out_target_height, out_invalid);
        fail_count++;
      end else begin
        want = pending_heights.pop_front();
        result_count++;
        if (want.bad) invalid_count++;
        if (out_target_height !== want.height) begin
          $display("%0t: target_height expected %0d actual %0d",
                   $time, want.height, out_target_height);
          fail_count++;
        end
        if (out_invalid !== want.bad) begin
          $display("%0t: invalid expected %0b actual %0b",
                   $time, want.bad, out_invalid);
          fail_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("%0t: run limit reached, %0d results outstanding",
               $time, pending_heights.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_RANGE_MIN;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_slant_range = '0;
    in_elevation = '0;
    in_azimuth = '0;
    in_site_height = '0;
    out_ready = 1'b0;
    steady = 0;
    fail_count = 0;
    result_count = 0;
    invalid_count = 0;
    cycle_count = 0;
    range_lo = 22'd0;
    range_hi = 22'h3FFFFF;
    elev_lo = 16'h8000;
    elev_hi = 16'h7FFF;
    azim_lo = 16'd0;
    azim_hi = 16'hFFFF;
    site_lo = 18'h3F800;
    site_hi = 18'h1FFFF;
    for (int i = 0; i < STAGES; i++) arctan_q60[i] = arctan_step(i);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_bounds();
    test_random(2000);
    drain_pipeline();

    $display("checked %0d results (%0d out of bounds) over default, narrow,",
             result_count, invalid_count);
    $display("crossed and random bound settings with random stalls");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/rth_pkg.sv
sv/rth_front.sv
sv/rth_rot_stage.sv
sv/rth_vec_stage.sv
sv/radar_target_height.sv
sv/rth_checker.sv
tb/radar_target_height_tb.sv
